>>> design/gss_pkg.sv
// shared constants, types and widths for the gyro sample scaler
package gss_pkg;

    localparam int CALIB_SAMPLES = 512;
    localparam int CNT_W         = $clog2(CALIB_SAMPLES + 1);

    localparam logic [20:0] GYRO_K      = 21'd1311823;
    localparam logic [21:0] ACCEL_K     = 22'd2569480;
    localparam logic [63:0] RUN_WAIT_US = 64'd50000;
    localparam int          GDA_BIT     = 1;
    localparam logic [9:0]  US_PER_MS   = 10'd1000;

    localparam int MUL_DIGITS = 4;
    localparam int MUL_CNT_W  = $clog2(MUL_DIGITS);
    localparam int DIV_STEPS  = 64;
    localparam int DIV_CNT_W  = $clog2(DIV_STEPS);
    localparam int SQRT_STEPS = 32;
    localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);

    localparam int PADDR_W = 5;

    localparam logic [2:0] REG_SENSOR_READY = 3'd0;
    localparam logic [2:0] REG_YAW_NEGATE   = 3'd1;
    localparam logic [2:0] REG_YAW_GAIN     = 3'd2;
    localparam logic [2:0] REG_YAW_BIAS     = 3'd3;
    localparam logic [2:0] REG_STALE_LIMIT  = 3'd4;

    typedef enum logic [1:0] {
        CAL_IDLE = 2'd0,
        CAL_RUN  = 2'd1,
        CAL_OK   = 2'd2,
        CAL_FAIL = 2'd3
    } calib_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_MUL_GAIN,
        ST_MUL_K,
        ST_MUL_ACC,
        ST_DIV_MEAN,
        ST_MUL_SQ,
        ST_DIV_SUM,
        ST_SQRT,
        ST_DONE
    } state_t;

    // request to the shared divider
    typedef struct packed {
        logic              start;
        logic              is_signed;
        logic [63:0]       dividend;
        logic [CNT_W-1:0]  divisor;
    } div_req_t;

endpackage

>>> design/gss_mul.sv
// iterative signed multiplier, one 8-bit digit of the second operand per cycle
module gss_mul (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               start,
    input  logic signed [39:0] a,
    input  logic signed [32:0] b,
    output logic               done,
    output logic [63:0]        prod
);

    logic [63:0]                      amag_reg;
    logic [31:0]                      bmag_reg;
    logic [63:0]                      acc_reg;
    logic                             neg_reg;
    logic [gss_pkg::MUL_CNT_W-1:0]    cnt_reg;
    logic                             busy_reg;
    logic                             done_reg;
    logic [39:0]                      a_abs;
    logic [32:0]                      b_abs;
    logic [71:0]                      part;

    assign a_abs = a[39] ? 40'(-a) : 40'(a);
    assign b_abs = b[32] ? 33'(-b) : 33'(b);
    assign part  = amag_reg * bmag_reg[7:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == gss_pkg::MUL_CNT_W'(gss_pkg::MUL_DIGITS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            amag_reg <= 64'(a_abs);
            bmag_reg <= b_abs[31:0];
            neg_reg  <= a[39] ^ b[32];
            acc_reg  <= '0;
        end
        else if (busy_reg)
        begin
            acc_reg  <= acc_reg + part[63:0];
            amag_reg <= {amag_reg[55:0], 8'd0};
            bmag_reg <= {8'd0, bmag_reg[31:8]};
        end
    end

    assign done = done_reg;
    assign prod = neg_reg ? 64'(-acc_reg) : acc_reg;

endmodule

>>> design/gss_div.sv
// restoring divider, one quotient bit per cycle, truncates toward zero
module gss_div (
    input  logic              clk,
    input  logic              rst_n,
    input  gss_pkg::div_req_t req,
    output logic              done,
    output logic [63:0]       quot
);

    logic [63:0]                  q_reg;
    logic [gss_pkg::CNT_W-1:0]    rem_reg;
    logic [gss_pkg::CNT_W-1:0]    dsr_reg;
    logic                         neg_reg;
    logic [gss_pkg::DIV_CNT_W-1:0] cnt_reg;
    logic                         busy_reg;
    logic                         done_reg;
    logic                         neg_in;
    logic [gss_pkg::CNT_W:0]      trial;
    logic [gss_pkg::CNT_W:0]      diff;

    assign neg_in = req.is_signed & req.dividend[63];
    assign trial  = {rem_reg, q_reg[63]};
    assign diff   = trial - {1'b0, dsr_reg};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == gss_pkg::DIV_CNT_W'(gss_pkg::DIV_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            q_reg   <= neg_in ? 64'(-req.dividend) : req.dividend;
            rem_reg <= '0;
            dsr_reg <= req.divisor;
            neg_reg <= neg_in;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dsr_reg})
            begin
                rem_reg <= diff[gss_pkg::CNT_W-1:0];
                q_reg   <= {q_reg[62:0], 1'b1};
            end
            else
            begin
                rem_reg <= trial[gss_pkg::CNT_W-1:0];
                q_reg   <= {q_reg[62:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign quot = neg_reg ? 64'(-q_reg) : q_reg;

endmodule

>>> design/gss_sqrt.sv
// floor square root of a 64-bit value, one root bit per cycle
module gss_sqrt (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [63:0] radicand,
    output logic        done,
    output logic [31:0] root
);

    logic [63:0]                    x_reg;
    logic [34:0]                    rem_reg;
    logic [31:0]                    root_reg;
    logic [gss_pkg::SQRT_CNT_W-1:0] cnt_reg;
    logic                           busy_reg;
    logic                           done_reg;
    logic [34:0]                    rem_sh;
    logic [34:0]                    trial;

    assign rem_sh = {rem_reg[32:0], x_reg[63:62]};
    assign trial  = {1'b0, root_reg, 2'b01};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= '0;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg + 1'b1;
                if (cnt_reg == gss_pkg::SQRT_CNT_W'(gss_pkg::SQRT_STEPS - 1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            x_reg    <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            x_reg <= {x_reg[61:0], 2'b00};
            if (rem_sh >= trial)
            begin
                rem_reg  <= rem_sh - trial;
                root_reg <= {root_reg[30:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_sh;
                root_reg <= {root_reg[30:0], 1'b0};
            end
        end
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

>>> design/gyro_sample_scaler_with_bias_calibration.sv
// top level: gyro/accel sample scaler with a welford bias calibration run
//
// usage
//   item channel (item_valid/item_ready): one transaction per sensor read
//   (func 0) or per calibration start (func 1). result channel
//   (result_valid/result_ready): exactly one result transaction per item.
//   apb port: sensor_ready, yaw_negate, yaw_gain, yaw_bias, stale_limit_ms
//   at byte addresses 0, 4, 8, 12, 16; write only while the block is idle.
// sequencing
//   one item at a time; item_ready is high only while the sequencer idles.
//   non-fresh read or start: no arithmetic, straight to the result register.
//   fresh read: 3 multiplies (start, 4 digit steps, hand-off) on the shared
//   digit multiplier. fresh read during a run adds a divide for the mean
//   step and a square multiply. the last sample of a run adds a divide of
//   the sum of squares and a square root. the iterative divider is the
//   slowest of the shared units.
// reset
//   rst_n clears control, config and calib registers, not data; no memories.
// stall
//   the result register holds while result_ready is low; a new item may be
//   taken as soon as the previous result sits in the output register.
module gyro_sample_scaler_with_bias_calibration (
    input  logic                        clk,
    input  logic                        rst_n,
    // apb
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [gss_pkg::PADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    // item channel
    input  logic                        item_valid,
    output logic                        item_ready,
    input  logic                        func,
    input  logic                        read_ok,
    input  logic [7:0]                  status_byte,
    input  logic signed [15:0]          gyro_raw,
    input  logic signed [15:0]          accel_raw,
    input  logic [63:0]                 now_us,
    // result channel
    output logic                        result_valid,
    input  logic                        result_ready,
    output logic signed [23:0]          rate_z,
    output logic signed [21:0]          accel_z,
    output logic                        fresh,
    output logic [63:0]                 sample_time,
    output logic                        healthy,
    output logic signed [15:0]          last_raw_gyro,
    output logic [1:0]                  calib_status,
    output logic signed [23:0]          calib_mean,
    output logic [22:0]                 calib_stddev
);

    localparam int CW = gss_pkg::CNT_W;

    // configuration registers
    logic               sensor_ready_reg;
    logic               yaw_negate_reg;
    logic [15:0]        yaw_gain_reg;
    logic signed [23:0] yaw_bias_reg;
    logic [15:0]        stale_limit_reg;

    // block state
    logic signed [15:0] last_gyro_reg;
    logic [63:0]        last_fresh_time_reg;
    logic               fresh_seen_reg;
    gss_pkg::calib_t    run_state_reg;
    logic [CW-1:0]      run_count_reg;
    logic [63:0]        run_deadline_reg;
    logic signed [39:0] mean_reg;
    logic [63:0]        sumsq_reg;
    logic signed [23:0] final_mean_reg;
    logic [22:0]        final_dev_reg;

    // sequencer
    gss_pkg::state_t    state_reg;
    gss_pkg::state_t    state_next;
    logic               start_reg;
    logic               start_next;

    // per-item working registers
    logic               func_reg;
    logic               fresh_reg;
    logic [63:0]        now_reg;
    logic signed [16:0] s_reg;
    logic signed [15:0] accel_in_reg;
    logic signed [32:0] p_reg;
    logic signed [23:0] pre_reg;
    logic signed [40:0] d1_reg;
    logic signed [23:0] yaw_reg;
    logic signed [21:0] accz_reg;

    // output register
    logic               out_valid_reg;
    logic signed [23:0] out_yaw_reg;
    logic signed [21:0] out_accz_reg;
    logic               out_fresh_reg;
    logic [63:0]        out_time_reg;
    logic               out_healthy_reg;
    logic signed [15:0] out_last_reg;
    logic [1:0]         out_status_reg;
    logic signed [23:0] out_mean_reg;
    logic [22:0]        out_dev_reg;

    // shared units
    logic               mul_start;
    logic signed [39:0] mul_a;
    logic signed [32:0] mul_b;
    logic               mul_done;
    logic [63:0]        mul_prod;
    gss_pkg::div_req_t  div_req;
    logic               div_done;
    logic [63:0]        div_quot;
    logic               sqrt_start;
    logic               sqrt_done;
    logic [31:0]        sqrt_root;

    // combinational helpers
    logic               accept;
    logic               fresh_in;
    logic               cfg_wr;
    logic [63:0]        pre_rnd;
    logic signed [23:0] pre_val;
    logic signed [24:0] yaw_diff;
    logic signed [23:0] yaw_sat;
    logic [63:0]        acc_rnd;
    logic signed [23:0] acc_val;
    logic signed [21:0] acc_sat;
    logic signed [40:0] xs;
    logic signed [40:0] d1_val;
    logic signed [40:0] d2_val;
    logic signed [41:0] rd1_sum;
    logic signed [41:0] rd2_sum;
    logic signed [25:0] rd1;
    logic signed [25:0] rd2;
    logic [CW-1:0]      cnt_inc;
    logic               run_last;
    logic signed [40:0] mean_rnd;
    logic [63:0]        age;
    logic [25:0]        age_limit;
    logic               healthy_now;
    logic               out_load;

    assign accept   = item_valid & item_ready;
    assign fresh_in = ~func & sensor_ready_reg & read_ok & status_byte[gss_pkg::GDA_BIT];
    assign cfg_wr   = psel & penable & pwrite & pready;

    // apb register file
    assign pready = 1'b1;

    always_comb
    begin
        case (paddr[4:2])
            gss_pkg::REG_SENSOR_READY: prdata = {31'd0, sensor_ready_reg};
            gss_pkg::REG_YAW_NEGATE:   prdata = {31'd0, yaw_negate_reg};
            gss_pkg::REG_YAW_GAIN:     prdata = {16'd0, yaw_gain_reg};
            gss_pkg::REG_YAW_BIAS:     prdata = {8'd0, yaw_bias_reg};
            gss_pkg::REG_STALE_LIMIT:  prdata = {16'd0, stale_limit_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sensor_ready_reg <= 1'b0;
            yaw_negate_reg   <= 1'b0;
            yaw_gain_reg     <= 16'd16384;
            yaw_bias_reg     <= '0;
            stale_limit_reg  <= 16'd100;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                gss_pkg::REG_SENSOR_READY: sensor_ready_reg <= pwdata[0];
                gss_pkg::REG_YAW_NEGATE:   yaw_negate_reg   <= pwdata[0];
                gss_pkg::REG_YAW_GAIN:     yaw_gain_reg     <= pwdata[15:0];
                gss_pkg::REG_YAW_BIAS:     yaw_bias_reg     <= pwdata[23:0];
                gss_pkg::REG_STALE_LIMIT:  stale_limit_reg  <= pwdata[15:0];
                default:                   ;
            endcase
        end
    end

    // yaw: round(p * K / 2^30), then bias removed and saturated to 24 bits
    assign pre_rnd  = mul_prod + 64'd536870912;
    assign pre_val  = pre_rnd[53:30];
    assign yaw_diff = 25'(pre_val) - 25'(yaw_bias_reg);
    assign yaw_sat  = (yaw_diff > 25'sd8388607)  ? 24'sd8388607 :
                      (yaw_diff < -25'sd8388608) ? -24'sd8388608 : yaw_diff[23:0];

    // accel: round(a * K / 2^16), clamped to +-20 g equivalent
    assign acc_rnd = mul_prod + 64'd32768;
    assign acc_val = acc_rnd[39:16];
    assign acc_sat = (acc_val > 24'sd1310720)  ? 22'sd1310720 :
                     (acc_val < -24'sd1310720) ? -22'sd1310720 : acc_val[21:0];

    // welford terms, mean held in 2^-32 units
    assign xs      = {pre_reg[23], pre_reg, 16'd0};
    assign d1_val  = xs - 41'(mean_reg);
    assign d2_val  = xs - 41'(mean_reg);
    assign rd1_sum = 42'(d1_reg) + 42'sd32768;
    assign rd2_sum = 42'(d2_val) + 42'sd32768;
    assign rd1     = rd1_sum[41:16];
    assign rd2     = rd2_sum[41:16];
    assign cnt_inc = run_count_reg + 1'b1;
    assign run_last = cnt_inc >= CW'(gss_pkg::CALIB_SAMPLES);
    assign mean_rnd = 41'(mean_reg) + 41'sd32768;

    // operand selection for the shared units
    always_comb
    begin
        case (state_reg)
            gss_pkg::ST_MUL_GAIN:
            begin
                mul_a = 40'(s_reg);
                mul_b = 33'($signed({1'b0, yaw_gain_reg}));
            end
            gss_pkg::ST_MUL_K:
            begin
                mul_a = 40'(p_reg);
                mul_b = 33'($signed({1'b0, gss_pkg::GYRO_K}));
            end
            gss_pkg::ST_MUL_ACC:
            begin
                mul_a = 40'(accel_in_reg);
                mul_b = 33'($signed({1'b0, gss_pkg::ACCEL_K}));
            end
            default:
            begin
                mul_a = 40'(rd1);
                mul_b = 33'(rd2);
            end
        endcase
    end

    assign mul_start = start_reg & (state_reg == gss_pkg::ST_MUL_GAIN ||
                                    state_reg == gss_pkg::ST_MUL_K ||
                                    state_reg == gss_pkg::ST_MUL_ACC ||
                                    state_reg == gss_pkg::ST_MUL_SQ);

    always_comb
    begin
        div_req.start = start_reg & (state_reg == gss_pkg::ST_DIV_MEAN ||
                                     state_reg == gss_pkg::ST_DIV_SUM);
        if (state_reg == gss_pkg::ST_DIV_SUM)
        begin
            div_req.is_signed = 1'b0;
            div_req.dividend  = sumsq_reg;
            div_req.divisor   = CW'(gss_pkg::CALIB_SAMPLES - 1);
        end
        else
        begin
            div_req.is_signed = 1'b1;
            div_req.dividend  = 64'(d1_reg);
            div_req.divisor   = cnt_inc;
        end
    end

    assign sqrt_start = start_reg & (state_reg == gss_pkg::ST_SQRT);

    gss_mul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mul_start),
        .a     (mul_a),
        .b     (mul_b),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    gss_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quot  (div_quot)
    );

    gss_sqrt u_sqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sqrt_start),
        .radicand (div_quot),
        .done     (sqrt_done),
        .root     (sqrt_root)
    );

    // health check on the state left by this item
    assign age         = now_reg - last_fresh_time_reg;
    assign age_limit   = stale_limit_reg * gss_pkg::US_PER_MS;
    assign healthy_now = sensor_ready_reg & fresh_seen_reg & (age <= 64'(age_limit));
    assign out_load    = (state_reg == gss_pkg::ST_DONE) & (~out_valid_reg | result_ready);

    // sequencer
    always_comb
    begin
        state_next = state_reg;
        start_next = 1'b0;
        case (state_reg)
            gss_pkg::ST_IDLE:
            begin
                if (accept)
                begin
                    if (fresh_in)
                    begin
                        state_next = gss_pkg::ST_MUL_GAIN;
                        start_next = 1'b1;
                    end
                    else
                    begin
                        state_next = gss_pkg::ST_DONE;
                    end
                end
            end
            gss_pkg::ST_MUL_GAIN:
            begin
                if (mul_done)
                begin
                    state_next = gss_pkg::ST_MUL_K;
                    start_next = 1'b1;
                end
            end
            gss_pkg::ST_MUL_K:
            begin
                if (mul_done)
                begin
                    state_next = gss_pkg::ST_MUL_ACC;
                    start_next = 1'b1;
                end
            end
            gss_pkg::ST_MUL_ACC:
            begin
                if (mul_done)
                begin
                    if (run_state_reg == gss_pkg::CAL_RUN)
                    begin
                        state_next = gss_pkg::ST_DIV_MEAN;
                        start_next = 1'b1;
                    end
                    else
                    begin
                        state_next = gss_pkg::ST_DONE;
                    end
                end
            end
            gss_pkg::ST_DIV_MEAN:
            begin
                if (div_done)
                begin
                    state_next = gss_pkg::ST_MUL_SQ;
                    start_next = 1'b1;
                end
            end
            gss_pkg::ST_MUL_SQ:
            begin
                if (mul_done)
                begin
                    if (run_last)
                    begin
                        state_next = gss_pkg::ST_DIV_SUM;
                        start_next = 1'b1;
                    end
                    else
                    begin
                        state_next = gss_pkg::ST_DONE;
                    end
                end
            end
            gss_pkg::ST_DIV_SUM:
            begin
                if (div_done)
                begin
                    state_next = gss_pkg::ST_SQRT;
                    start_next = 1'b1;
                end
            end
            gss_pkg::ST_SQRT:
            begin
                if (sqrt_done)
                begin
                    state_next = gss_pkg::ST_DONE;
                end
            end
            gss_pkg::ST_DONE:
            begin
                if (out_load)
                begin
                    state_next = gss_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = gss_pkg::ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= gss_pkg::ST_IDLE;
            start_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            start_reg <= start_next;
        end
    end

    assign item_ready = (state_reg == gss_pkg::ST_IDLE);

    // calibration and freshness state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            last_gyro_reg       <= '0;
            last_fresh_time_reg <= '0;
            fresh_seen_reg      <= 1'b0;
            run_state_reg       <= gss_pkg::CAL_IDLE;
            run_count_reg       <= '0;
            run_deadline_reg    <= '0;
            mean_reg            <= '0;
            sumsq_reg           <= '0;
            final_mean_reg      <= '0;
            final_dev_reg       <= '0;
        end
        else
        begin
            if (accept)
            begin
                if (fresh_in)
                begin
                    last_gyro_reg       <= gyro_raw;
                    last_fresh_time_reg <= now_us;
                    fresh_seen_reg      <= 1'b1;
                end
                if (func)
                begin
                    if (!sensor_ready_reg)
                    begin
                        run_state_reg <= gss_pkg::CAL_FAIL;
                    end
                    else
                    begin
                        // start, or restart of a run in progress
                        run_state_reg    <= gss_pkg::CAL_RUN;
                        run_count_reg    <= '0;
                        mean_reg         <= '0;
                        sumsq_reg        <= '0;
                        run_deadline_reg <= now_us + gss_pkg::RUN_WAIT_US;
                    end
                end
                else if (run_state_reg == gss_pkg::CAL_RUN && !fresh_in &&
                         now_us >= run_deadline_reg)
                begin
                    run_state_reg <= gss_pkg::CAL_FAIL;
                end
            end

            if (state_reg == gss_pkg::ST_DIV_MEAN && div_done)
            begin
                mean_reg <= mean_reg + div_quot[39:0];
            end

            if (state_reg == gss_pkg::ST_MUL_SQ && mul_done)
            begin
                sumsq_reg     <= sumsq_reg + mul_prod;
                run_count_reg <= cnt_inc;
                if (run_last)
                begin
                    final_mean_reg <= mean_rnd[39:16];
                end
                else
                begin
                    run_deadline_reg <= now_reg + gss_pkg::RUN_WAIT_US;
                end
            end

            if (state_reg == gss_pkg::ST_SQRT && sqrt_done)
            begin
                final_dev_reg <= (|sqrt_root[31:23]) ? 23'h7FFFFF : sqrt_root[22:0];
                run_state_reg <= gss_pkg::CAL_OK;
            end
        end
    end

    // per-item working registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg     <= func;
            fresh_reg    <= fresh_in;
            now_reg      <= now_us;
            s_reg        <= yaw_negate_reg ? -17'(gyro_raw) : 17'(gyro_raw);
            accel_in_reg <= accel_raw;
            yaw_reg      <= '0;
            accz_reg     <= '0;
        end
        if (state_reg == gss_pkg::ST_MUL_GAIN && mul_done)
        begin
            p_reg <= mul_prod[32:0];
        end
        if (state_reg == gss_pkg::ST_MUL_K && mul_done)
        begin
            pre_reg <= pre_val;
            yaw_reg <= yaw_sat;
        end
        if (state_reg == gss_pkg::ST_MUL_ACC && mul_done)
        begin
            accz_reg <= acc_sat;
            d1_reg   <= d1_val;
        end
    end

    // output register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (result_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_yaw_reg     <= yaw_reg;
            out_accz_reg    <= accz_reg;
            out_fresh_reg   <= fresh_reg;
            out_time_reg    <= now_reg;
            out_healthy_reg <= healthy_now;
            out_last_reg    <= last_gyro_reg;
            out_status_reg  <= run_state_reg;
            out_mean_reg    <= final_mean_reg;
            out_dev_reg     <= final_dev_reg;
        end
    end

    assign result_valid  = out_valid_reg;
    assign rate_z        = out_yaw_reg;
    assign accel_z       = out_accz_reg;
    assign fresh         = out_fresh_reg;
    assign sample_time   = out_time_reg;
    assign healthy       = out_healthy_reg;
    assign last_raw_gyro = out_last_reg;
    assign calib_status  = out_status_reg;
    assign calib_mean    = out_mean_reg;
    assign calib_stddev  = out_dev_reg;

`ifndef ASSERT_OFF
    // one item at a time: an accepted transaction closes the item channel
    a_one_item: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> !item_ready)
        else $error("item accepted while another is in flight");

    // a start transaction never reports fresh data
    a_start_not_fresh: assert property (@(posedge clk) disable iff (!rst_n)
        out_load && func_reg |=> !fresh && rate_z == 24'sd0 && accel_z == 22'sd0)
        else $error("start transaction produced sensor data");

    // run counter never passes the sample count
    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        run_count_reg <= CW'(gss_pkg::CALIB_SAMPLES))
        else $error("calibration counter overran");

    // a finished run always leaves the full sample count behind
    a_ok_count: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(run_state_reg == gss_pkg::CAL_OK) |->
            run_count_reg == CW'(gss_pkg::CALIB_SAMPLES))
        else $error("run finished early");
`endif

endmodule

>>> bench/tb_gyro_sample_scaler_with_bias_calibration.sv
// self-checking testbench for the gyro sample scaler with bias calibration
module tb_gyro_sample_scaler_with_bias_calibration;

    timeunit 1ns;
    timeprecision 1ps;

    // one expected result transaction
    typedef struct {
        logic signed [23:0] rate_z;
        logic signed [21:0] accel_z;
        logic               fresh;
        logic [63:0]        sample_time;
        logic               healthy;
        logic signed [15:0] last_raw_gyro;
        gss_pkg::calib_t    calib_status;
        logic signed [23:0] calib_mean;
        logic [22:0]        calib_stddev;
    } scaled_sample_t;

    logic                        clk;
    logic                        rst_n;
    logic                        psel;
    logic                        penable;
    logic                        pwrite;
    logic [gss_pkg::PADDR_W-1:0] paddr;
    logic [31:0]                 pwdata;
    logic [31:0]                 prdata;
    logic                        pready;
    logic                        item_valid;
    logic                        item_ready;
    logic                        func;
    logic                        read_ok;
    logic [7:0]                  status_byte;
    logic signed [15:0]          gyro_raw;
    logic signed [15:0]          accel_raw;
    logic [63:0]                 now_us;
    logic                        result_valid;
    logic                        result_ready;
    logic signed [23:0]          rate_z;
    logic signed [21:0]          accel_z;
    logic                        fresh;
    logic [63:0]                 sample_time;
    logic                        healthy;
    logic signed [15:0]          last_raw_gyro;
    logic [1:0]                  calib_status;
    logic signed [23:0]          calib_mean;
    logic [22:0]                 calib_stddev;

    gyro_sample_scaler_with_bias_calibration dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .item_valid    (item_valid),
        .item_ready    (item_ready),
        .func          (func),
        .read_ok       (read_ok),
        .status_byte   (status_byte),
        .gyro_raw      (gyro_raw),
        .accel_raw     (accel_raw),
        .now_us        (now_us),
        .result_valid  (result_valid),
        .result_ready  (result_ready),
        .rate_z        (rate_z),
        .accel_z       (accel_z),
        .fresh         (fresh),
        .sample_time   (sample_time),
        .healthy       (healthy),
        .last_raw_gyro (last_raw_gyro),
        .calib_status  (calib_status),
        .calib_mean    (calib_mean),
        .calib_stddev  (calib_stddev)
    );

    // shadow copy of the configuration registers
    logic               cfg_ready;
    logic               cfg_negate;
    logic [15:0]        cfg_gain;
    logic signed [23:0] cfg_bias;
    logic [15:0]        cfg_stale_ms;

    // shadow copy of the scaler and calibration state
    logic signed [15:0] last_gyro;
    logic [63:0]        last_fresh_time;
    logic               fresh_seen;
    gss_pkg::calib_t    run_state;
    int                 run_count;
    logic [63:0]        run_deadline;
    longint             mean_acc;       // running mean, 2^-32 units
    logic [63:0]        sq_accum;       // 2^-32 units squared
    logic signed [23:0] final_mean;
    logic [22:0]        final_stddev;

    scaled_sample_t pending_samples[$];
    int             error_count;
    int             sender_idle_pct;
    int             receiver_stall_pct;
    logic [63:0]    clock_us;           // running sensor time stamp

    // round to nearest, halves toward plus infinity
    function automatic longint round_shift(longint v, int s);
        return (v + (longint'(1) <<< (s - 1))) >>> s;
    endfunction

    function automatic longint clamp(longint v, longint lo, longint hi);
        return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function automatic logic [63:0] floor_sqrt(logic [63:0] v);
        logic [63:0] r;
        logic [63:0] b;
        r = 0;
        b = 64'd1 << 62;
        while (b > v)
            b = b >> 2;
        while (b != 0)
        begin
            if (v >= r + b)
            begin
                v = v - (r + b);
                r = (r >> 1) + b;
            end
            else
                r = r >> 1;
            b = b >> 2;
        end
        return r;
    endfunction

    // expected result of one accepted transaction; advances the shadow state
    function automatic scaled_sample_t scale_and_calibrate(logic f, logic ok, logic [7:0] st,
            logic signed [15:0] g, logic signed [15:0] a, logic [63:0] t);
        scaled_sample_t e;
        logic    is_fresh;
        longint  s;
        longint  pre;
        longint  xs;
        longint  d1;
        longint  d2;
        logic [63:0] sd;
        is_fresh = (f == 1'b0) && cfg_ready && ok && st[gss_pkg::GDA_BIT];
        pre = 0;
        e.rate_z = 0;
        e.accel_z = 0;
        if (is_fresh)
        begin
            s = cfg_negate ? -longint'(g) : longint'(g);
            pre = round_shift(s * longint'(cfg_gain) * longint'(gss_pkg::GYRO_K), 30);
            last_gyro = g;
            last_fresh_time = t;
            fresh_seen = 1'b1;
            e.rate_z = 24'(clamp(pre - longint'(cfg_bias), -8388608, 8388607));
            e.accel_z = 22'(clamp(round_shift(longint'(a) * longint'(gss_pkg::ACCEL_K), 16),
                                  -1310720, 1310720));
        end
        if (f == 1'b1)
        begin
            if (!cfg_ready)
                run_state = gss_pkg::CAL_FAIL;
            else
            begin
                run_state = gss_pkg::CAL_RUN;
                run_count = 0;
                mean_acc = 0;
                sq_accum = 0;
                run_deadline = t + gss_pkg::RUN_WAIT_US;
            end
        end
        else if (run_state == gss_pkg::CAL_RUN)
        begin
            if (is_fresh)
            begin
                xs = pre * 65536;
                d1 = xs - mean_acc;
                mean_acc = mean_acc + d1 / longint'(run_count + 1);
                d2 = xs - mean_acc;
                sq_accum = sq_accum + 64'(round_shift(d1, 16) * round_shift(d2, 16));
                run_count++;
                if (run_count >= gss_pkg::CALIB_SAMPLES)
                begin
                    sd = floor_sqrt(sq_accum / 64'(gss_pkg::CALIB_SAMPLES - 1));
                    final_mean = 24'(clamp(round_shift(mean_acc, 16), -8388608, 8388607));
                    final_stddev = sd > 64'd8388607 ? 23'd8388607 : 23'(sd);
                    run_state = gss_pkg::CAL_OK;
                end
                else
                    run_deadline = t + gss_pkg::RUN_WAIT_US;
            end
            else if (t >= run_deadline)
                run_state = gss_pkg::CAL_FAIL;
        end
        e.fresh = is_fresh;
        e.sample_time = t;
        e.healthy = cfg_ready && fresh_seen &&
                    ((t - last_fresh_time) <= 64'(cfg_stale_ms) * 64'(gss_pkg::US_PER_MS));
        e.last_raw_gyro = last_gyro;
        e.calib_status = run_state;
        e.calib_mean = final_mean;
        e.calib_stddev = final_stddev;
        return e;
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // watchdog
    initial
    begin
        #30ms;
        $display("tb_gyro_sample_scaler_with_bias_calibration: errors");
        $finish;
    end

    // receiver: random stalls, driven at the falling edge
    always @(negedge clk)
        result_ready <= ($urandom_range(99) >= receiver_stall_pct);

    // checker: compare every result transaction with the oldest expectation
    always @(posedge clk)
    begin
        scaled_sample_t e;
        if (rst_n && result_valid && result_ready)
        begin
            if (pending_samples.size() == 0)
            begin
                $error("result transaction with no expectation pending");
                error_count++;
            end
            else
            begin
                e = pending_samples.pop_front();
                if (rate_z !== e.rate_z)
                begin
                    $error("rate_z exp %0d got %0d", e.rate_z, rate_z);
                    error_count++;
                end
                if (accel_z !== e.accel_z)
                begin
                    $error("accel_z exp %0d got %0d", e.accel_z, accel_z);
                    error_count++;
                end
                if (fresh !== e.fresh)
                begin
                    $error("fresh exp %0b got %0b", e.fresh, fresh);
                    error_count++;
                end
                if (sample_time !== e.sample_time)
                begin
                    $error("sample_time exp %0h got %0h", e.sample_time, sample_time);
                    error_count++;
                end
                if (healthy !== e.healthy)
                begin
                    $error("healthy exp %0b got %0b", e.healthy, healthy);
                    error_count++;
                end
                if (last_raw_gyro !== e.last_raw_gyro)
                begin
                    $error("last_raw_gyro exp %0d got %0d", e.last_raw_gyro, last_raw_gyro);
                    error_count++;
                end
                if (calib_status !== e.calib_status)
                begin
                    $error("calib_status exp %0d got %0d", e.calib_status, calib_status);
                    error_count++;
                end
                if (calib_mean !== e.calib_mean)
                begin
                    $error("calib_mean exp %0d got %0d", e.calib_mean, calib_mean);
                    error_count++;
                end
                if (calib_stddev !== e.calib_stddev)
                begin
                    $error("calib_stddev exp %0d got %0d", e.calib_stddev, calib_stddev);
                    error_count++;
                end
            end
        end
    end

    // apb write: setup cycle then access cycle, register taken at the access edge
    task automatic apb_write(logic [2:0] idx, logic [31:0] value);
        psel = 1'b1;
        pwrite = 1'b1;
        penable = 1'b0;
        paddr = {idx, 2'b00};
        pwdata = value;
        @(negedge clk);
        penable = 1'b1;
        @(negedge clk);
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        case (idx)
            gss_pkg::REG_SENSOR_READY: cfg_ready = value[0];
            gss_pkg::REG_YAW_NEGATE:   cfg_negate = value[0];
            gss_pkg::REG_YAW_GAIN:     cfg_gain = value[15:0];
            gss_pkg::REG_YAW_BIAS:     cfg_bias = value[23:0];
            gss_pkg::REG_STALE_LIMIT:  cfg_stale_ms = value[15:0];
            default: ;
        endcase
    endtask

    // send one item transaction; called and returning at a falling edge
    task automatic send_item(logic f, logic ok, logic [7:0] st, logic signed [15:0] g,
            logic signed [15:0] a, logic [63:0] t);
        while ($urandom_range(99) < sender_idle_pct)
            @(negedge clk);
        item_valid = 1'b1;
        func = f;
        read_ok = ok;
        status_byte = st;
        gyro_raw = g;
        accel_raw = a;
        now_us = t;
        do
            @(posedge clk);
        while (!item_ready);
        pending_samples.push_back(scale_and_calibrate(f, ok, st, g, a, t));
        @(negedge clk);
        item_valid = 1'b0;
    endtask

    // block idle: all results back plus the longest internal tail
    task automatic drain();
        while (pending_samples.size() != 0)
            @(negedge clk);
        repeat (250) @(negedge clk);
    endtask

    task automatic send_fresh(logic signed [15:0] g, logic signed [15:0] a, int dt);
        clock_us += 64'(dt);
        send_item(1'b0, 1'b1, 8'h02, g, a, clock_us);
    endtask

    // one random read; mostly fresh, small time steps, rare large jumps
    task automatic send_random_read();
        logic [7:0]  st;
        logic signed [15:0] g;
        int r;
        r = $urandom_range(99);
        st = 8'($urandom());
        st[gss_pkg::GDA_BIT] = ($urandom_range(99) < 88);
        g = ($urandom_range(3) == 0) ? 16'($urandom()) : 16'($signed($urandom_range(400)) - 200);
        if (r < 2)
            clock_us = {$urandom(), $urandom()};
        else if (r < 5)
            clock_us += 64'($urandom_range(200000));
        else
            clock_us += 64'($urandom_range(30000));
        send_item(1'b0, ($urandom_range(99) < 95), st, g, 16'($urandom()), clock_us);
    endtask

    task automatic test_reset_and_not_ready();
        // sensor not ready: nothing is fresh, a start fails at once
        send_item(1'b0, 1'b1, 8'hFF, 16'sh7FFF, 16'sh7FFF, 64'd10);
        send_item(1'b1, 1'b1, 8'hFF, 16'sh1234, 16'sh1234, 64'd20);
        drain();
        apb_write(gss_pkg::REG_SENSOR_READY, 32'd1);
    endtask

    task automatic test_scaling_extremes();
        send_item(1'b0, 1'b1, 8'h02, 16'sh7FFF, 16'sh7FFF, 64'd1000);
        send_item(1'b0, 1'b1, 8'hFF, -16'sd32768, -16'sd32768, 64'd2000);
        send_item(1'b0, 1'b1, 8'hFD, 16'sd100, 16'sd100, 64'd3000);      // data-ready bit clear
        send_item(1'b0, 1'b0, 8'h02, 16'sd200, 16'sd200, 64'd4000);      // bus read failed
        send_item(1'b0, 1'b1, 8'h02, 16'sd0, 16'sd0, 64'd5000);
        send_item(1'b0, 1'b1, 8'h02, -16'sd1, 16'sd1, 64'd6000);
        drain();
        apb_write(gss_pkg::REG_YAW_NEGATE, 32'd1);
        apb_write(gss_pkg::REG_YAW_GAIN, 32'hFFFF);
        apb_write(gss_pkg::REG_YAW_BIAS, 32'h007F_FFFF);
        send_item(1'b0, 1'b1, 8'h02, 16'sh7FFF, -16'sd5, 64'd7000);
        send_item(1'b0, 1'b1, 8'h02, -16'sd32768, 16'sd5, 64'd8000);
        drain();
        apb_write(gss_pkg::REG_YAW_BIAS, 32'h0080_0000);
        apb_write(gss_pkg::REG_YAW_GAIN, 32'd0);
        send_item(1'b0, 1'b1, 8'h02, 16'sh7FFF, 16'sd7, 64'd9000);
        drain();
        apb_write(gss_pkg::REG_YAW_NEGATE, 32'd0);
        apb_write(gss_pkg::REG_YAW_GAIN, 32'd16384);
        apb_write(gss_pkg::REG_YAW_BIAS, 32'h00FF_FFF0);
        send_item(1'b0, 1'b1, 8'h02, 16'sd123, 16'sd321, 64'd10000);
    endtask

    task automatic test_health_and_time_wrap();
        drain();
        apb_write(gss_pkg::REG_STALE_LIMIT, 32'd0);
        send_item(1'b0, 1'b1, 8'h02, 16'sd1, 16'sd1, 64'hFFFF_FFFF_FFFF_FFF0);
        send_item(1'b0, 1'b0, 8'h00, 16'sd1, 16'sd1, 64'hFFFF_FFFF_FFFF_FFF0);
        send_item(1'b0, 1'b0, 8'h00, 16'sd1, 16'sd1, 64'hFFFF_FFFF_FFFF_FFF1);
        drain();
        apb_write(gss_pkg::REG_STALE_LIMIT, 32'hFFFF);
        send_item(1'b0, 1'b0, 8'h00, 16'sd1, 16'sd1, 64'd5);           // wraps past zero
        send_item(1'b0, 1'b0, 8'h00, 16'sd1, 16'sd1, 64'd65535000);
        drain();
        apb_write(gss_pkg::REG_STALE_LIMIT, 32'd100);
    endtask

    task automatic test_calibration_fail_and_restart();
        clock_us = 64'd1_000_000;
        send_item(1'b1, 1'b0, 8'h00, 16'sd0, 16'sd0, clock_us);
        send_fresh(16'sd50, 16'sd0, 1000);
        send_item(1'b1, 1'b1, 8'h02, 16'sd0, 16'sd0, clock_us);        // restart mid run
        clock_us += 64'd49999;
        send_item(1'b0, 1'b0, 8'h02, 16'sd0, 16'sd0, clock_us);        // just before deadline
        clock_us += 64'd1;
        send_item(1'b0, 1'b1, 8'h00, 16'sd0, 16'sd0, clock_us);        // exactly at deadline
    endtask

    // complete run of calibration samples around a random bias
    task automatic test_calibration_run();
        int center;
        center = $urandom_range(2000) - 1000;
        send_item(1'b1, 1'b1, 8'h00, 16'sd0, 16'sd0, clock_us);
        // pause once until everything outstanding has come back
        while (pending_samples.size() != 0)
            @(negedge clk);
        for (int i = 0; i < gss_pkg::CALIB_SAMPLES; i++)
            send_fresh(16'(center + int'($urandom_range(60)) - 30), 16'($urandom()),
                       $urandom_range(20000));
    endtask

    task automatic test_random_traffic(int count);
        for (int i = 0; i < count; i++)
        begin
            if ($urandom_range(99) < 3)
                send_item(1'b1, 1'($urandom()), 8'($urandom()), 16'($urandom()),
                          16'($urandom()), clock_us);
            else
                send_random_read();
        end
    endtask

    task automatic randomize_config();
        apb_write(gss_pkg::REG_SENSOR_READY, ($urandom_range(9) != 0));
        apb_write(gss_pkg::REG_YAW_NEGATE, $urandom_range(1));
        apb_write(gss_pkg::REG_YAW_GAIN, ($urandom_range(3) == 0) ? $urandom_range(65535)
                                                             : $urandom_range(14000, 19000));
        apb_write(gss_pkg::REG_YAW_BIAS, ($urandom_range(3) == 0) ? $urandom()
                                                             : $urandom_range(4000));
        apb_write(gss_pkg::REG_STALE_LIMIT, ($urandom_range(3) == 0) ? $urandom_range(65535)
                                                                : $urandom_range(5, 200));
    endtask

    initial
    begin
        int stall_modes[4][2];
        stall_modes = '{'{0, 0}, '{54, 0}, '{0, 54}, '{38, 38}};
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        item_valid = 1'b0;
        func = 1'b0;
        read_ok = 1'b0;
        status_byte = '0;
        gyro_raw = '0;
        accel_raw = '0;
        now_us = '0;
        result_ready = 1'b0;
        error_count = 0;
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        clock_us = 0;
        // shadow state at its reset values
        cfg_ready = 1'b0;
        cfg_negate = 1'b0;
        cfg_gain = 16'd16384;
        cfg_bias = 0;
        cfg_stale_ms = 16'd100;
        last_gyro = 0;
        last_fresh_time = 0;
        fresh_seen = 1'b0;
        run_state = gss_pkg::CAL_IDLE;
        run_count = 0;
        run_deadline = 0;
        mean_acc = 0;
        sq_accum = 0;
        final_mean = 0;
        final_stddev = 0;
        repeat (6) @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_reset_and_not_ready();
        test_scaling_extremes();
        test_health_and_time_wrap();
        test_calibration_fail_and_restart();
        sender_idle_pct = 38;
        receiver_stall_pct = 38;
        test_calibration_run();
        for (int p = 0; p < 4; p++)
        begin
            drain();
            sender_idle_pct = stall_modes[p][0];
            receiver_stall_pct = stall_modes[p][1];
            randomize_config();
            test_random_traffic(170);
        end

        drain();
        if (error_count == 0)
            $display("tb_gyro_sample_scaler_with_bias_calibration: clean");
        else
            $display("tb_gyro_sample_scaler_with_bias_calibration: errors");
        $finish;
    end

endmodule
